@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CBE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbe assertion failed");

// next-cycle implication
`define CBE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbe assertion failed");

`endif

@@ rtl/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cbe_pkg
// types and codes shared by the character buffer edit engine
// ----------------------------------------------------------------------------
package cbe_pkg;

  // width of position fields broadcast to the cells, covers the largest capacity
  localparam int POS_W = 17;

  // width of the reported length field on the result channel
  localparam int OUT_LEN_W = 9;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_ERASE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_WRITE   = 3'd5,
    CMD_REVERSE = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_UNDER = 2'd2,
    STAT_OVER  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REV,
    ST_READ,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_WRITE,
    CELL_SWAP,
    CELL_RD_LOAD,
    CELL_RD_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] len;
    logic             phase;
    logic [7:0]       ch;
  } cell_ctrl_t;

endpackage

@@ rtl/cbe_in_if.sv @@
// ----------------------------------------------------------------------------
// cbe_in_if
// command channel: valid/ready with cmd, index and char_in
// ----------------------------------------------------------------------------
interface cbe_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic signed [8:0] index;
  logic [7:0]        char_in;

  modport source (output valid, cmd, index, char_in, input ready);
  modport sink   (input valid, cmd, index, char_in, output ready);
endinterface

@@ rtl/cbe_out_if.sv @@
// ----------------------------------------------------------------------------
// cbe_out_if
// result channel: valid/ready with char_out, length, flags and status
// ----------------------------------------------------------------------------
interface cbe_out_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      char_out;
  logic [cbe_pkg::OUT_LEN_W-1:0]   length;
  logic                            is_empty;
  logic                            is_full;
  logic [1:0]                      status;

  modport source (output valid, char_out, length, is_empty, is_full, status, input ready);
  modport sink   (input valid, char_out, length, is_empty, is_full, status, output ready);
endinterface

@@ rtl/cbe_cell.sv @@
// ----------------------------------------------------------------------------
// cbe_cell
// one character slot of the chain, plus one stage of the read-out line
// ----------------------------------------------------------------------------
module cbe_cell #(
  parameter int unsigned POS = 0
) (
  input  logic               clk,
  input  cbe_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         left_data,
  input  logic [7:0]         right_data,
  input  logic [7:0]         right_rd,
  output logic [7:0]         data,
  output logic [7:0]         rd
);

  localparam logic [cbe_pkg::POS_W-1:0] K  = cbe_pkg::POS_W'(POS);
  localparam logic [cbe_pkg::POS_W-1:0] K1 = cbe_pkg::POS_W'(POS + 1);
  localparam logic                      KP = K[0];

  logic [7:0] data_r, data_nxt;
  logic [7:0] rd_r, rd_nxt;

  always_comb begin
    data_nxt = data_r;
    rd_nxt   = rd_r;
    case (ctrl.op)
      cbe_pkg::CELL_INSERT: begin
        if (K == ctrl.pos) begin
          data_nxt = ctrl.ch;
        end else if (K > ctrl.pos && K <= ctrl.len) begin
          data_nxt = left_data;
        end
      end
      cbe_pkg::CELL_ERASE: begin
        if (K >= ctrl.pos && K1 < ctrl.len) begin
          data_nxt = right_data;
        end
      end
      cbe_pkg::CELL_WRITE: begin
        if (K == ctrl.pos) begin
          data_nxt = ctrl.ch;
        end
      end
      cbe_pkg::CELL_SWAP: begin
        // lower slot of an active pair takes its right neighbor, upper slot its left
        if (KP == ctrl.phase && K1 < ctrl.len) begin
          data_nxt = right_data;
        end else if (POS != 0 && KP != ctrl.phase && K < ctrl.len) begin
          data_nxt = left_data;
        end
      end
      cbe_pkg::CELL_RD_LOAD: begin
        rd_nxt = (K == ctrl.pos) ? data_r : 8'd0;
      end
      cbe_pkg::CELL_RD_SHIFT: begin
        rd_nxt = right_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rd_r   <= rd_nxt;
  end

  assign data = data_r;
  assign rd   = rd_r;

endmodule

@@ rtl/cbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbe_ctrl
// command sequencer: fill count, cell control broadcast and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbe_ctrl #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  cbe_in_if.sink              in_ch,
  cbe_out_if.source           out_ch,
  input  logic [7:0]          rd0,
  output cbe_pkg::cell_ctrl_t cell_ctrl
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (LEN_W > 8) ? LEN_W : 8;
  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

  cbe_pkg::state_t    state_r, state_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   aux_r, aux_nxt;
  cbe_pkg::cmd_t      cmd_r;
  logic signed [8:0]  idx_r;
  logic [7:0]         ch_r;
  logic [7:0]         pend_char_r, pend_char_nxt;
  cbe_pkg::status_t   pend_stat_r, pend_stat_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic               out_full_r, out_full_nxt;
  cbe_pkg::status_t   out_stat_r, out_stat_nxt;

  logic               in_fire, slot_free;
  logic               idx_neg, in_rng, past_end, is_full;
  logic [CMP_W-1:0]   idx_u, len_c;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  assign idx_neg  = idx_r[8];
  assign idx_u    = CMP_W'(idx_r[7:0]);
  assign len_c    = CMP_W'(cnt_r);
  assign in_rng   = !idx_neg && (idx_u < len_c);
  assign past_end = !idx_neg && (idx_u >= len_c);
  assign is_full  = (cnt_r == CAP_L);

  // command capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cbe_pkg::cmd_t'(in_ch.cmd);
      idx_r <= in_ch.index;
      ch_r  <= in_ch.char_in;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbe_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = cbe_pkg::ST_EXEC;
      end
      cbe_pkg::ST_EXEC: begin
        if (cmd_r == cbe_pkg::CMD_READ && in_rng) begin
          state_nxt = cbe_pkg::ST_READ;
        end else if (cmd_r == cbe_pkg::CMD_REVERSE && cnt_r >= LEN_W'(2)) begin
          state_nxt = cbe_pkg::ST_REV;
        end else begin
          state_nxt = cbe_pkg::ST_DONE;
        end
      end
      cbe_pkg::ST_REV: begin
        if (aux_r == cnt_r - LEN_W'(1)) state_nxt = cbe_pkg::ST_DONE;
      end
      cbe_pkg::ST_READ: begin
        if (aux_r == '0) state_nxt = cbe_pkg::ST_DONE;
      end
      cbe_pkg::ST_DONE: begin
        if (slot_free) state_nxt = cbe_pkg::ST_IDLE;
      end
      default: state_nxt = cbe_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cnt_nxt       = cnt_r;
    aux_nxt       = aux_r;
    pend_char_nxt = pend_char_r;
    pend_stat_nxt = pend_stat_r;
    cell_ctrl.op    = cbe_pkg::CELL_HOLD;
    cell_ctrl.pos   = cbe_pkg::POS_W'(idx_r[7:0]);
    cell_ctrl.len   = cbe_pkg::POS_W'(cnt_r);
    cell_ctrl.phase = aux_r[0];
    cell_ctrl.ch    = ch_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_len_nxt   = out_len_r;
    out_empty_nxt = out_empty_r;
    out_full_nxt  = out_full_r;
    out_stat_nxt  = out_stat_r;
    unique case (state_r)
      cbe_pkg::ST_IDLE: begin
      end
      cbe_pkg::ST_EXEC: begin
        pend_char_nxt = 8'd0;
        pend_stat_nxt = cbe_pkg::STAT_OK;
        unique case (cmd_r) inside
          cbe_pkg::CMD_APPEND, cbe_pkg::CMD_INSERT: begin
            if ((cmd_r == cbe_pkg::CMD_APPEND) || past_end) begin
              if (is_full) begin
                pend_stat_nxt = cbe_pkg::STAT_OVER;
              end else begin
                cell_ctrl.op  = cbe_pkg::CELL_WRITE;
                cell_ctrl.pos = cbe_pkg::POS_W'(cnt_r);
                cnt_nxt       = cnt_r + LEN_W'(1);
              end
            end else if (is_full) begin
              pend_stat_nxt = cbe_pkg::STAT_OVER;
            end else begin
              cell_ctrl.op  = cbe_pkg::CELL_INSERT;
              cell_ctrl.pos = idx_neg ? '0 : cbe_pkg::POS_W'(idx_r[7:0]);
              cnt_nxt       = cnt_r + LEN_W'(1);
            end
          end
          cbe_pkg::CMD_REMOVE: begin
            if (cnt_r == '0) begin
              pend_stat_nxt = cbe_pkg::STAT_UNDER;
            end else begin
              cnt_nxt = cnt_r - LEN_W'(1);
            end
          end
          cbe_pkg::CMD_ERASE: begin
            if (!in_rng) begin
              pend_stat_nxt = cbe_pkg::STAT_RANGE;
            end else begin
              cell_ctrl.op = cbe_pkg::CELL_ERASE;
              cnt_nxt      = cnt_r - LEN_W'(1);
            end
          end
          cbe_pkg::CMD_READ: begin
            if (!in_rng) begin
              pend_stat_nxt = cbe_pkg::STAT_RANGE;
            end else begin
              cell_ctrl.op = cbe_pkg::CELL_RD_LOAD;
              aux_nxt      = LEN_W'(idx_r[7:0]);
            end
          end
          cbe_pkg::CMD_WRITE: begin
            if (!in_rng) begin
              pend_stat_nxt = cbe_pkg::STAT_RANGE;
            end else begin
              cell_ctrl.op = cbe_pkg::CELL_WRITE;
            end
          end
          cbe_pkg::CMD_REVERSE: begin
            aux_nxt = '0;
          end
          default: begin
            cnt_nxt = '0;
          end
        endcase
      end
      cbe_pkg::ST_REV: begin
        // one odd-even transposition round per cycle
        cell_ctrl.op = cbe_pkg::CELL_SWAP;
        aux_nxt      = aux_r + LEN_W'(1);
      end
      cbe_pkg::ST_READ: begin
        if (aux_r == '0) begin
          pend_char_nxt = rd0;
        end else begin
          cell_ctrl.op = cbe_pkg::CELL_RD_SHIFT;
          aux_nxt      = aux_r - LEN_W'(1);
        end
      end
      cbe_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = pend_char_r;
          out_len_nxt   = cnt_r;
          out_empty_nxt = (cnt_r == '0);
          out_full_nxt  = is_full;
          out_stat_nxt  = pend_stat_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbe_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    aux_r       <= aux_nxt;
    pend_char_r <= pend_char_nxt;
    pend_stat_r <= pend_stat_nxt;
    out_char_r  <= out_char_nxt;
    out_len_r   <= out_len_nxt;
    out_empty_r <= out_empty_nxt;
    out_full_r  <= out_full_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign in_ch.ready     = (state_r == cbe_pkg::ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_char_r;
  assign out_ch.length   = cbe_pkg::OUT_LEN_W'(out_len_r);
  assign out_ch.is_empty = out_empty_r;
  assign out_ch.is_full  = out_full_r;
  assign out_ch.status   = out_stat_r;

  `CBE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CAP_L)
  `CBE_ASSERT_NXT(a_fire_exec, in_fire, state_r == cbe_pkg::ST_EXEC)
  `CBE_ASSERT_IMP(a_empty_flag, out_valid_r, out_empty_r == (out_len_r == '0))
  `CBE_ASSERT_IMP(a_full_flag, out_valid_r, out_full_r == (out_len_r == CAP_L))
  `CBE_ASSERT_NXT(a_done_wait, state_r == cbe_pkg::ST_DONE && !slot_free,
                  state_r == cbe_pkg::ST_DONE)

endmodule

@@ rtl/char_buffer_edit_engine_top.sv @@
// sequence: append, remove, insert, erase, write, clear run in EXEC; DONE then loads the result
// sequence: read puts the character in the read-out line, which shifts one slot per cycle
// sequence: reverse on L >= 2 characters runs transposition rounds, one round a cycle
// throughput: one item at a time, next transfer taken the cycle after the result is loaded
// reset: rst_n (synchronous) clears fill count, sequencer and result valid; cells are not cleared
// ----------------------------------------------------------------------------
// char_buffer_edit_engine_top
// fixed-capacity character buffer built as a chain of character cells
// ----------------------------------------------------------------------------
module char_buffer_edit_engine_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  cbe_in_if.sink    in_ch,
  cbe_out_if.source out_ch
);

  // control broadcast to every cell; each cell decides from its own position
  cbe_pkg::cell_ctrl_t cell_ctrl;

  // neighbor links of the chain: stored characters and the read-out line
  logic [7:0] data_w [CAPACITY];
  logic [7:0] rd_w   [CAPACITY];

  // sequencer: decodes the command, keeps the fill count, owns the result register
  cbe_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .rd0       (rd_w[0]),
    .cell_ctrl (cell_ctrl)
  );

  // row of cells, slot 0 at the front of the buffer
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] left_d, right_d, right_r;

    // chain ends see zero from outside
    if (g == 0) begin : g_first
      assign left_d = 8'd0;
    end else begin : g_mid_l
      assign left_d = data_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = 8'd0;
      assign right_r = 8'd0;
    end else begin : g_mid_r
      assign right_d = data_w[g+1];
      assign right_r = rd_w[g+1];
    end

    cbe_cell #(
      .POS (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .right_rd   (right_r),
      .data       (data_w[g]),
      .rd         (rd_w[g])
    );
  end

endmodule
